>>> design/msps_pkg.sv
// msps_pkg: shared types, codes and sizing for the sensor poll scheduler.
// No dependencies; imported by every module of the block.
package msps_pkg;

  // Slot count and derived widths.
  localparam int SLOTS        = 4;
  localparam int RES_N        = (SLOTS > 2) ? SLOTS : 2;   // result entries per item
  localparam int SLOT_W       = $clog2(RES_N);
  localparam int NUM_INTERVALS = 4;
  localparam int IVAL_IDX_W   = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Register reset values.
  localparam logic [15:0] TIMEOUT_RST    = 16'd500;
  localparam logic [3:0]  MAX_ERRORS_RST = 4'd3;
  localparam logic [3:0]  ERR_SAT        = 4'd15;

  typedef enum logic [2:0] {
    M_TICK   = 3'd0,
    M_DONE   = 3'd1,
    M_READ   = 3'd2,
    M_START  = 3'd3,
    M_STOP   = 3'd4,
    M_RESET  = 3'd5,
    M_REJECT = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    K_ARM     = 3'd0,
    K_DATA    = 3'd1,
    K_FAIL    = 3'd2,
    K_TIMEOUT = 3'd3,
    K_OK      = 3'd4,
    K_NODEV   = 3'd5,
    K_BUSY    = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    CFG_SLOT_COUNT = 3'd0,
    CFG_TIMEOUT    = 3'd1,
    CFG_MAX_ERRORS = 3'd2,
    CFG_INTERVAL_0 = 3'd3,
    CFG_INTERVAL_1 = 3'd4,
    CFG_INTERVAL_2 = 3'd5,
    CFG_INTERVAL_3 = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CMD,
    S_POST
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  slot;
    logic [31:0] now_ms;
    logic        status_ok;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] slot_out;
    logic       last;
  } result_t;

  // Results collected for one item, handed to the emitter in one go.
  typedef struct packed {
    logic [RES_N-1:0]       mask;
    logic [RES_N-1:0][2:0]  kind;
    logic [RES_N-1:0][1:0]  slot;
  } batch_t;

  // Age compare outcome from the shared time unit.
  typedef struct packed {
    logic timed_out;  // age >  timeout
    logic elapsed;    // age >= interval
  } age_cmp_t;

  function automatic logic [3:0] err_sat_inc(input logic [3:0] cnt);
    logic [3:0] r;
    r = (cnt < ERR_SAT) ? cnt + 4'd1 : cnt;
    return r;
  endfunction

endpackage

>>> design/msps_age_unit.sv
// msps_age_unit: shared wrapping age subtract with timeout and interval compares.
// Depends on msps_pkg.
module msps_age_unit (
  input  logic [31:0]       now_ms,
  input  logic [31:0]       arm_time,
  input  logic [15:0]       timeout,
  input  logic [15:0]       interval,
  output msps_pkg::age_cmp_t cmp
);
  import msps_pkg::*;

  logic [31:0] age;

  // Modulo 2^32 difference.
  assign age           = now_ms - arm_time;
  assign cmp.timed_out = age > 32'(timeout);
  assign cmp.elapsed   = age >= 32'(interval);

endmodule

>>> design/msps_emitter.sv
// msps_emitter: drains one item's result batch through the output register.
// Depends on msps_pkg.
module msps_emitter (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  msps_pkg::batch_t  batch,
  output logic              busy,
  output logic              result_valid,
  input  logic              result_stall,
  output msps_pkg::result_t result
);
  import msps_pkg::*;

  logic [RES_N-1:0]      mask;
  logic [RES_N-1:0][2:0] kind;
  logic [RES_N-1:0][1:0] slot;
  logic [SLOT_W-1:0]     pick;
  logic                  found;
  logic [RES_N-1:0]      mask_rest;
  logic                  out_free;
  logic                  fire;

  // Lowest pending entry goes first.
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int i = 0; i < RES_N; i++) begin
      if (mask[i] && !found) begin
        pick  = SLOT_W'(i);
        found = 1'b1;
      end
    end
    mask_rest       = mask;
    mask_rest[pick] = 1'b0;
  end

  assign busy     = |mask;
  assign out_free = !result_valid || !result_stall;
  assign fire     = busy && out_free && !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (load) begin
        mask <= batch.mask;
      end else if (fire) begin
        mask <= mask_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind <= batch.kind;
      slot <= batch.slot;
    end
    if (fire) begin
      result.kind     <= kind[pick];
      result.slot_out <= slot[pick];
      result.last     <= ~|mask_rest;
    end
  end

endmodule

>>> design/multi_sensor_poll_scheduler_unit.sv
// multi_sensor_poll_scheduler_unit: top level of the per-slot sensor read scheduler.
// Depends on msps_pkg, msps_age_unit and msps_emitter.
//
//   channel  | signals                          | payload
//   ---------+----------------------------------+-----------------------------------
//   item     | item_valid, item_stall           | item_t: mode, slot, now_ms, status_ok
//   result   | result_valid, result_stall       | result_t: kind, slot_out, last
//   cfg      | cfg_valid, cfg_ready             | cfg_index, cfg_data
//
// A tick latches the item, walks the slots one by one through the shared age unit
// (S_SCAN), then posts its batch (S_POST); results then leave one per cycle while
// the output is not stalled. A command goes through S_CMD and S_POST, then its results.
// item_stall stays high until the last result of the transaction is in the output
// register, so the next transaction overlaps with a waiting result.
// Synchronous reset clears all slot state and loads register reset values.
// cfg_ready is always high; configuration is to be written only while idle, which the block itself does not enforce.
module multi_sensor_poll_scheduler_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  msps_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output msps_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [msps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msps_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import msps_pkg::*;

  // Configuration registers.
  logic [2:0]  slot_count;
  logic [15:0] timeout;
  logic [3:0]  max_errors;
  logic [15:0] interval [NUM_INTERVALS];
  logic [2:0]  ival_off;

  // Slot state.
  logic        pending     [SLOTS];
  logic        streaming   [SLOTS];
  logic [3:0]  err_cnt     [SLOTS];
  logic [31:0] arm_time    [SLOTS];

  // Sequencer.
  state_t            state, state_next;
  item_t             item_q;
  logic [SLOT_W-1:0] idx;
  batch_t            batch;
  logic              accept;
  logic              emit_busy;
  logic              batch_load;

  // Per-step slot update.
  logic [2:0]        active;
  logic              in_range;
  logic [SLOT_W-1:0] sel;
  logic              cur_pend, cur_strm;
  logic [3:0]        cur_err, err_inc;
  logic              err_stop;
  age_cmp_t          cmp;
  logic              upd;
  logic              new_pend, new_strm;
  logic [3:0]        new_err;
  logic              set_time;
  logic              lo_v, hi_v;
  kind_t             lo_k, hi_k;
  logic [SLOT_W-1:0] lo_pos;
  logic [1:0]        ent_slot;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE) || emit_busy;
  assign accept     = item_valid && !item_stall;
  assign batch_load = (state == S_POST);

  // ---------------- configuration ----------------
  assign ival_off = cfg_index - CFG_INTERVAL_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
      timeout    <= TIMEOUT_RST;
      max_errors <= MAX_ERRORS_RST;
      for (int i = 0; i < NUM_INTERVALS; i++) begin
        interval[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        CFG_SLOT_COUNT: slot_count <= cfg_data[2:0];
        CFG_TIMEOUT:    timeout    <= cfg_data;
        CFG_MAX_ERRORS: max_errors <= cfg_data[3:0];
        [CFG_INTERVAL_0:CFG_INTERVAL_3]: begin
          interval[ival_off[IVAL_IDX_W-1:0]] <= cfg_data;
        end
        default: ;  // index beyond the register list
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (item.mode == M_TICK) ? S_SCAN : S_CMD;
        end
      end
      S_SCAN: begin
        if (idx == SLOT_W'(SLOTS - 1)) begin
          state_next = S_POST;
        end
      end
      S_CMD:  state_next = S_POST;
      S_POST: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= '0;
    end else if (state == S_SCAN) begin
      idx <= idx + 1'b1;
    end
  end

  // ---------------- slot evaluation ----------------
  // Oversized slot_count clamps to the slot array size.
  assign active   = (slot_count > 3'(SLOTS)) ? 3'(SLOTS) : slot_count;
  assign in_range = item_q.slot < active;
  assign sel      = (state == S_SCAN) ? idx : item_q.slot[SLOT_W-1:0];
  assign cur_pend = pending[sel];
  assign cur_strm = streaming[sel];
  assign cur_err  = err_cnt[sel];
  assign err_inc  = err_sat_inc(cur_err);
  assign err_stop = err_inc >= max_errors;
  assign ent_slot = (state == S_SCAN) ? 2'(idx) : item_q.slot[1:0];

  msps_age_unit u_age (
    .now_ms   (item_q.now_ms),
    .arm_time (arm_time[sel]),
    .timeout  (timeout),
    .interval (interval[IVAL_IDX_W'(sel)]),
    .cmp      (cmp)
  );

  always_comb begin
    upd      = 1'b0;
    new_pend = cur_pend;
    new_strm = cur_strm;
    new_err  = cur_err;
    set_time = 1'b0;
    lo_v     = 1'b0;
    lo_k     = K_ARM;
    hi_v     = 1'b0;
    hi_k     = K_OK;
    lo_pos   = '0;
    if (state == S_SCAN) begin
      lo_pos = idx;
      if (3'(idx) < active) begin
        if (cur_pend && cmp.timed_out) begin
          upd      = 1'b1;
          new_pend = 1'b0;
          new_err  = err_inc;
          new_strm = cur_strm && !err_stop;
          lo_v     = 1'b1;
          lo_k     = K_TIMEOUT;
        end else if (cur_strm && !cur_pend && cmp.elapsed) begin
          upd      = 1'b1;
          new_pend = 1'b1;
          set_time = 1'b1;
          lo_v     = 1'b1;
          lo_k     = K_ARM;
        end
      end
    end else if (state == S_CMD) begin
      if (item_q.mode == M_REJECT) begin
        if (in_range) begin
          upd      = 1'b1;
          new_pend = 1'b0;
        end
      end else if (item_q.mode == M_TICK || item_q.mode > M_REJECT) begin
        upd = 1'b0;  // unused mode: nothing happens
      end else if (!in_range) begin
        hi_v = 1'b1;
        hi_k = K_NODEV;
      end else begin
        upd  = 1'b1;
        hi_v = 1'b1;
        case (item_q.mode)
          M_DONE: begin
            new_pend = 1'b0;
            if (item_q.status_ok) begin
              new_err = '0;
              hi_k    = K_DATA;
            end else begin
              new_err  = err_inc;
              new_strm = cur_strm && !err_stop;
              hi_k     = K_FAIL;
            end
          end
          M_READ: begin
            if (cur_pend) begin
              hi_k = K_BUSY;
            end else begin
              new_pend = 1'b1;
              set_time = 1'b1;
              lo_v     = 1'b1;
            end
          end
          M_START: begin
            new_strm = 1'b1;
            if (!cur_pend) begin
              new_pend = 1'b1;
              set_time = 1'b1;
              lo_v     = 1'b1;
            end
          end
          M_STOP: new_strm = 1'b0;
          default: begin
            // slot reset
            new_err  = '0;
            new_pend = 1'b0;
            new_strm = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        pending[i]   <= 1'b0;
        streaming[i] <= 1'b0;
        err_cnt[i]   <= '0;
        arm_time[i]  <= '0;
      end
    end else if (upd) begin
      pending[sel]   <= new_pend;
      streaming[sel] <= new_strm;
      err_cnt[sel]   <= new_err;
      if (set_time) begin
        arm_time[sel] <= item_q.now_ms;
      end
    end
  end

  // Result batch: scan fills one entry per slot; commands use entry 0 for the
  // arm request and entry 1 for the answer.
  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_N; i++) begin
      if (rst || accept) begin
        batch.mask[i] <= 1'b0;
      end else if (lo_v && (lo_pos == SLOT_W'(i))) begin
        batch.mask[i] <= 1'b1;
        batch.kind[i] <= lo_k;
        batch.slot[i] <= ent_slot;
      end else if (hi_v && (i == 1)) begin
        batch.mask[i] <= 1'b1;
        batch.kind[i] <= hi_k;
        batch.slot[i] <= ent_slot;
      end
    end
  end

  msps_emitter u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (batch_load),
    .batch        (batch),
    .busy         (emit_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTH
  // A no-device answer is always the only result of its transaction.
  a_nodev_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == K_NODEV) |-> result.last)
    else $error("no-device result without last");

  // A tick goes to the slot walk, every other mode to the command step.
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((state == S_SCAN) == (item_q.mode == M_TICK)))
    else $error("item dispatched to wrong step");

  // A new batch never lands on one still draining.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    batch_load |-> !emit_busy)
    else $error("batch loaded while emitter busy");

  // The walk ends at the last slot, and the batch posts in the next cycle.
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && (idx == SLOT_W'(SLOTS - 1)) |=> batch_load)
    else $error("slot walk did not post its batch");
`endif

endmodule

>>> tb/sv/multi_sensor_poll_scheduler_unit_tb.sv
// Self-checking testbench for multi_sensor_poll_scheduler_unit: a directed table, then
// randomized command/tick traffic over several register setups, checked by a local model.
// Depends on msps_pkg and the multi_sensor_poll_scheduler_unit RTL only.
module multi_sensor_poll_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msps_pkg::*;

  // Mode 7 has no member in mode_t; the block must ignore it.
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  localparam int BOOT_ROWS       = 5;          // table rows run with slot_count at reset (0)
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 34;
  localparam int SETTLE_CYCLES   = SLOTS + 12; // covers a tick that yields no result
  localparam int DRAIN_LIMIT     = 20000;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct {
    item_t   it;
    bit      typed;   // want holds a hand-written single expected result
    result_t want;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  item_t                 item_in      = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result_out;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  always #6 clk = ~clk;

  multi_sensor_poll_scheduler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Scheduler model: per-slot state plus a shadow of the register file.
  // ---------------------------------------------------------------------------
  logic        pend    [SLOTS];
  logic        strm    [SLOTS];
  logic [3:0]  errs    [SLOTS];
  logic [31:0] arm_at  [SLOTS];
  logic [2:0]  reg_slots;
  logic [15:0] reg_timeout;
  logic [3:0]  reg_max_err;
  logic [15:0] reg_ival [NUM_INTERVALS];

  result_t     step_res [SLOTS];   // results of the transaction just modeled
  result_t     due_q [$];          // results still owed by the DUT, oldest first
  stim_row_t   dir_rows [$];

  logic [31:0] now_base;           // running millisecond clock for random traffic
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches      = 0;
  int          items_sent      = 0;
  int          results_checked = 0;
  int          cycle_count     = 0;

  task automatic reset_model();
    reg_slots   = '0;
    reg_timeout = TIMEOUT_RST;
    reg_max_err = MAX_ERRORS_RST;
    for (int i = 0; i < NUM_INTERVALS; i++) reg_ival[i] = '0;
    for (int i = 0; i < SLOTS; i++) begin
      pend[i]   = 1'b0;
      strm[i]   = 1'b0;
      errs[i]   = '0;
      arm_at[i] = '0;
    end
  endtask

  function automatic result_t make_result(input kind_t k, input int s);
    result_t r;
    r.kind     = k;
    r.slot_out = s[1:0];
    r.last     = 1'b0;
    return r;
  endfunction

  // Failure or timeout: saturating count, streaming drops at the threshold.
  function automatic void count_fault(input int i);
    if (errs[i] < ERR_SAT) errs[i] = errs[i] + 4'd1;
    if (errs[i] >= reg_max_err) strm[i] = 1'b0;
  endfunction

  function automatic int arm_slot(input int i, input logic [31:0] t, input int n);
    pend[i]     = 1'b1;
    arm_at[i]   = t;
    step_res[n] = make_result(K_ARM, i);
    return n + 1;
  endfunction

  // Advances the model by one input transaction; fills step_res, returns the count.
  function automatic int schedule_step(input item_t it);
    int          n;
    int          act;
    int          s;
    logic [31:0] age;
    n   = 0;
    act = (reg_slots > SLOTS) ? SLOTS : int'(reg_slots);
    s   = int'(it.slot);
    if (it.mode == M_TICK) begin
      for (int i = 0; i < act; i++) begin
        age = it.now_ms - arm_at[i];   // wraps mod 2^32
        if (pend[i] && age > {16'd0, reg_timeout}) begin
          pend[i] = 1'b0;
          count_fault(i);
          step_res[n] = make_result(K_TIMEOUT, i);
          n++;
        end else if (strm[i] && !pend[i] && age >= {16'd0, reg_ival[i]}) begin
          n = arm_slot(i, it.now_ms, n);
        end
      end
    end else if (it.mode == M_REJECT) begin
      if (s < act) pend[s] = 1'b0;
    end else if (it.mode != MODE_UNUSED) begin
      if (s >= act) begin
        step_res[n] = make_result(K_NODEV, s);
        n++;
      end else begin
        case (it.mode)
          M_DONE: begin
            pend[s] = 1'b0;
            if (it.status_ok) begin
              errs[s]     = '0;
              step_res[n] = make_result(K_DATA, s);
            end else begin
              count_fault(s);
              step_res[n] = make_result(K_FAIL, s);
            end
            n++;
          end
          M_READ: begin
            if (pend[s]) begin
              step_res[n] = make_result(K_BUSY, s);
              n++;
            end else begin
              n = arm_slot(s, it.now_ms, n);
              step_res[n] = make_result(K_OK, s);
              n++;
            end
          end
          M_START: begin
            strm[s] = 1'b1;
            if (!pend[s]) n = arm_slot(s, it.now_ms, n);
            step_res[n] = make_result(K_OK, s);
            n++;
          end
          M_STOP: begin
            strm[s]     = 1'b0;
            step_res[n] = make_result(K_OK, s);
            n++;
          end
          default: begin
            errs[s]     = '0;
            pend[s]     = 1'b0;
            strm[s]     = 1'b0;
            step_res[n] = make_result(K_OK, s);
            n++;
          end
        endcase
      end
    end
    if (n > 0) step_res[n-1].last = 1'b1;
    return n;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers. Everything toggles on the falling edge; handshakes are sampled on
  // the rising edge, before the DUT's own updates land.
  // ---------------------------------------------------------------------------

  // Result side back-pressure, re-rolled every cycle.
  always @(negedge clk)
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  // One input transaction: optional idle gap, then hold until accepted.
  // Valid is left high afterwards so back-to-back transactions need no extra edge.
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item_in    <= it;
    do @(posedge clk); while (item_stall);
    n = schedule_step(it);
    if (typed) due_q.push_back(want);
    else for (int k = 0; k < n; k++) due_q.push_back(step_res[k]);
    items_sent++;
  endtask

  // Drop valid, wait for every owed result, then let a silent tick finish.
  task automatic wait_drain();
    int guard;
    guard = 0;
    @(negedge clk);
    item_valid <= 1'b0;
    while (due_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SLOT_COUNT: reg_slots   = val[2:0];
      CFG_TIMEOUT:    reg_timeout = val;
      CFG_MAX_ERRORS: reg_max_err = val[3:0];
      CFG_INTERVAL_0: reg_ival[0] = val;
      CFG_INTERVAL_1: reg_ival[1] = val;
      CFG_INTERVAL_2: reg_ival[2] = val;
      default:        reg_ival[3] = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input logic [15:0] slots, input logic [15:0] tmo,
                              input logic [15:0] maxe, input logic [15:0] i0,
                              input logic [15:0] i1, input logic [15:0] i2,
                              input logic [15:0] i3);
    write_reg(CFG_SLOT_COUNT, slots);
    write_reg(CFG_TIMEOUT,    tmo);
    write_reg(CFG_MAX_ERRORS, maxe);
    write_reg(CFG_INTERVAL_0, i0);
    write_reg(CFG_INTERVAL_1, i1);
    write_reg(CFG_INTERVAL_2, i2);
    write_reg(CFG_INTERVAL_3, i3);
  endtask

  task automatic add_row(input logic [2:0] md, input logic [2:0] sl, input logic [31:0] t,
                         input logic okb, input bit typed, input kind_t k,
                         input logic [1:0] so);
    stim_row_t row;
    row.it.mode        = md;
    row.it.slot        = sl;
    row.it.now_ms      = t;
    row.it.status_ok   = okb;
    row.typed          = typed;
    row.want.kind      = k;
    row.want.slot_out  = so;
    row.want.last      = 1'b1;
    dir_rows.push_back(row);
  endtask

  // Directed table. Rows before BOOT_ROWS run with no active slots; the rest with
  // four. Hand-written expectations only where the answer is obvious.
  task automatic build_table();
    // no active slots: every addressed command but reject is "no device", tick is silent
    add_row(M_READ,      3'd0, 32'd0,          1'b0, 1, K_NODEV,   2'd0);
    add_row(M_DONE,      3'd7, 32'hFFFF_FFFF,  1'b1, 1, K_NODEV,   2'd3);
    add_row(M_TICK,      3'd0, 32'd0,          1'b0, 0, K_ARM,     2'd0);
    add_row(M_REJECT,    3'd0, 32'd0,          1'b0, 0, K_ARM,     2'd0);
    add_row(MODE_UNUSED, 3'd7, 32'hFFFF_FFFF,  1'b1, 0, K_ARM,     2'd0);
    // four slots, reset timeout and error threshold
    add_row(M_START,     3'd0, 32'd0,          1'b0, 0, K_ARM,     2'd0);
    add_row(M_READ,      3'd0, 32'd1,          1'b0, 1, K_BUSY,    2'd0);
    add_row(M_READ,      3'd1, 32'd100,        1'b0, 0, K_ARM,     2'd0);
    add_row(M_TICK,      3'd0, 32'd500,        1'b0, 0, K_ARM,     2'd0);  // age == timeout
    add_row(M_TICK,      3'd0, 32'd501,        1'b0, 1, K_TIMEOUT, 2'd0);  // one past it
    add_row(M_TICK,      3'd0, 32'd502,        1'b0, 0, K_ARM,     2'd0);  // stream re-arm
    add_row(M_DONE,      3'd0, 32'd503,        1'b0, 1, K_FAIL,    2'd0);
    add_row(M_DONE,      3'd0, 32'd504,        1'b1, 1, K_DATA,    2'd0);
    add_row(M_STOP,      3'd0, 32'd505,        1'b0, 1, K_OK,      2'd0);
    add_row(M_RESET,     3'd1, 32'd506,        1'b0, 1, K_OK,      2'd1);
    add_row(M_REJECT,    3'd1, 32'd507,        1'b0, 0, K_ARM,     2'd0);
    add_row(M_DONE,      3'd5, 32'd508,        1'b1, 1, K_NODEV,   2'd1);
    add_row(M_STOP,      3'd7, 32'd509,        1'b0, 1, K_NODEV,   2'd3);
    // pending read armed just below the wrap point, then aged across it
    add_row(M_READ,      3'd2, 32'hFFFF_FFF0,  1'b0, 0, K_ARM,     2'd0);
    add_row(M_TICK,      3'd0, 32'h0000_0100,  1'b0, 0, K_ARM,     2'd0);
    add_row(M_TICK,      3'd5, 32'h0000_0200,  1'b1, 1, K_TIMEOUT, 2'd2);
    add_row(M_START,     3'd3, 32'h0000_0200,  1'b0, 0, K_ARM,     2'd0);
    add_row(M_RESET,     3'd3, 32'h0000_0201,  1'b0, 1, K_OK,      2'd3);
    add_row(M_TICK,      3'd7, 32'hFFFF_FFFF,  1'b1, 0, K_ARM,     2'd0);
    add_row(MODE_UNUSED, 3'd0, 32'd0,          1'b0, 0, K_ARM,     2'd0);
  endtask

  // Random transaction: time moves forward in steps scaled to the timeout, with
  // an occasional wild jump; completions and rejects mostly target pending slots.
  function automatic item_t random_item();
    item_t it;
    int    r;
    int    pick;
    bit    found;
    r = $urandom_range(0, 99);
    if (r < 70)      now_base += $urandom_range(0, (reg_timeout >> 2) + 8);
    else if (r < 92) now_base += $urandom_range(0, reg_timeout + 40);
    else             now_base += $urandom;
    r = $urandom_range(0, 99);
    if (r < 36)      it.mode = M_TICK;
    else if (r < 52) it.mode = M_DONE;
    else if (r < 66) it.mode = M_READ;
    else if (r < 76) it.mode = M_START;
    else if (r < 81) it.mode = M_STOP;
    else if (r < 86) it.mode = M_RESET;
    else if (r < 97) it.mode = M_REJECT;
    else             it.mode = MODE_UNUSED;
    if ($urandom_range(0, 99) < 85) it.slot = 3'($urandom_range(0, 3));
    else                            it.slot = 3'($urandom_range(0, 7));
    if ((it.mode == M_DONE || it.mode == M_REJECT) && $urandom_range(0, 99) < 70) begin
      pick  = $urandom_range(0, SLOTS - 1);
      found = 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        if (!found && pend[(pick + k) % SLOTS]) begin
          it.slot = 3'((pick + k) % SLOTS);
          found   = 1'b1;
        end
      end
    end
    it.now_ms    = now_base;
    it.status_ok = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result transaction against the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_checked++;
      if (due_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result kind=%0d slot=%0d last=%0d",
                                result_out.kind, result_out.slot_out, result_out.last));
      end else begin
        want = due_q.pop_front();
        if (result_out.kind !== want.kind)
          note_mismatch($sformatf("kind %0d, want %0d", result_out.kind, want.kind));
        if (result_out.slot_out !== want.slot_out)
          note_mismatch($sformatf("slot_out %0d, want %0d",
                                  result_out.slot_out, want.slot_out));
        if (result_out.last !== want.last)
          note_mismatch($sformatf("last %0d, want %0d", result_out.last, want.last));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results owed",
               cycle_count, due_q.size());
      $display("** multi_sensor_poll_scheduler_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin
    result_t none;
    none = '0;
    reset_model();
    build_table();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed table under the first idle pattern.
    send_idle_pct = 32;
    recv_idle_pct = 74;
    for (int r = 0; r < dir_rows.size(); r++) begin
      if (r == BOOT_ROWS) begin
        wait_drain();
        write_reg(CFG_SLOT_COUNT, 16'd4);
      end
      send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want);
    end

    // Random phases, each with its own register setup; idle pattern swaps every
    // two phases and the last two run at full rate on both sides.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drain();
      if (p < 2) begin
        send_idle_pct = 32;
        recv_idle_pct = 74;
      end else if (p < 4) begin
        send_idle_pct = 74;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: program_regs(16'd4, 16'd40,    16'd3,  16'd0, 16'd10, 16'd25, 16'hFFFF);
        1: program_regs(16'd7, 16'd0,     16'd1,  16'd5, 16'd0, 16'hFFFF, 16'd3);
        2: program_regs(16'd2, 16'hFFFF,  16'd15, 16'd0, 16'd0, 16'd0, 16'd0);
        3: program_regs(16'd3, 16'd100,   16'd0,  16'($urandom_range(0, 60)),
                        16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)),
                        16'($urandom_range(0, 60)));
        4: program_regs(16'd4, 16'd30,    16'd2,  16'($urandom_range(0, 40)),
                        16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                        16'($urandom_range(0, 40)));
        default: program_regs(16'd5, 16'd60, 16'd15, 16'($urandom_range(0, 80)),
                              16'($urandom_range(0, 80)), 16'($urandom_range(0, 80)),
                              16'($urandom_range(0, 80)));
      endcase
      now_base = $urandom;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // mid-phase: hold the sender until the DUT has returned everything
        if (k == ITEMS_PER_PHASE / 2) wait_drain();
        send_item(random_item(), 1'b0, none);
      end
    end

    wait_drain();
    while (due_q.size() != 0) begin
      none = due_q.pop_front();
      note_mismatch($sformatf("result never arrived: kind=%0d slot=%0d last=%0d",
                              none.kind, none.slot_out, none.last));
    end

    $display("Covered %0d input transactions and %0d result transactions over %0d setups,",
             items_sent, results_checked, RANDOM_PHASES + 1);
    $display("with sender and receiver back-pressure swapped and removed; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("** multi_sensor_poll_scheduler_unit: PASSED **");
    end else begin
      $display("** multi_sensor_poll_scheduler_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
design/msps_pkg.sv
design/msps_age_unit.sv
design/msps_emitter.sv
design/multi_sensor_poll_scheduler_unit.sv
tb/sv/multi_sensor_poll_scheduler_unit_tb.sv
